### src/mrac_pkg.sv
// ----------------------------------------------------------------------------
// mrac_pkg: shared types and constants of the adaptive drive controller
// Register map, register reset values, sequencer step codes and the control
// word of the shared fixed-point multiplier.
// ----------------------------------------------------------------------------
package mrac_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_GAIN_W = 31;
  localparam int CFG_TS_W   = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_VEL  = 3'd0,
    CFG_GAIN_ACC  = 3'd1,
    CFG_GAIN_FRIC = 3'd2,
    CFG_LEAK_VEL  = 3'd3,
    CFG_LEAK_ACC  = 3'd4,
    CFG_LEAK_FRIC = 3'd5,
    CFG_PERIOD    = 3'd6
  } cfg_idx_t;

  localparam logic [CFG_GAIN_W-1:0] GAIN_VEL_RST  = 31'd327680;
  localparam logic [CFG_GAIN_W-1:0] GAIN_ACC_RST  = 31'd131072;
  localparam logic [CFG_GAIN_W-1:0] GAIN_FRIC_RST = 31'd196608;
  localparam logic [CFG_GAIN_W-1:0] LEAK_RST      = 31'd1966080;
  localparam logic [CFG_TS_W-1:0]   PERIOD_RST    = 17'd655;

  // stored gains are clamped to +/- this many units
  localparam int GAIN_LIMIT = 5;

  // one step per product, in issue order
  typedef enum logic [3:0] {
    STEP_PA = 4'd0,   // k1 * v
    STEP_PB = 4'd1,   // k2 * r, drive formed
    STEP_PC = 4'd2,   // Ts/2 * (r + r_prev), model velocity
    STEP_K1 = 4'd3,   // unclamped gains
    STEP_K2 = 4'd4,
    STEP_K3 = 4'd5,
    STEP_Q1 = 4'd6,   // adaptation gain * e
    STEP_Q2 = 4'd7,
    STEP_Q3 = 4'd8,
    STEP_T1 = 4'd9,   // (g * e) * v
    STEP_T2 = 4'd10,  // (g * e) * r
    STEP_L1 = 4'd11,  // leak * k, integrator update
    STEP_L2 = 4'd12,
    STEP_L3 = 4'd13
  } step_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_HI   = 4'b0010,
    M_LO   = 4'b0100,
    M_FIN  = 4'b1000
  } mul_state_t;

  typedef struct packed {
    logic start;
    logic half;   // extra right shift for a Ts/2 factor
  } mul_ctl_t;

  // magnitude width the multiplier must carry: data sums or gain registers
  function automatic int mag_width(input int dw);
    return (dw + 1 > CFG_GAIN_W) ? dw + 1 : CFG_GAIN_W;
  endfunction

endpackage

### src/mrac_in_if.sv
// ----------------------------------------------------------------------------
// mrac_in_if: sample channel
// Measured velocity and desired acceleration with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrac_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] velocity;
  logic signed [DATA_WIDTH-1:0] desired_accel;

  modport source (output valid, output velocity, output desired_accel, input ready);
  modport sink   (input valid, input velocity, input desired_accel, output ready);
endinterface

### src/mrac_out_if.sv
// ----------------------------------------------------------------------------
// mrac_out_if: drive command channel
// Saturated actuator drive with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrac_out_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

### src/mrac_cfg_if.sv
// ----------------------------------------------------------------------------
// mrac_cfg_if: register write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrac_cfg_if ();
  import mrac_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/mrac_drive_controller.sv
// ----------------------------------------------------------------------------
// mrac_drive_controller: adaptive drive controller
// Model-reference adaptive drive law with leaky trapezoidal gain integrators.
// ----------------------------------------------------------------------------
// Each sample transaction (velocity, desired acceleration) produces one drive
// transaction u = k1*v + k2*r + k3*sign(v) from the gains of the previous
// sample; the block then advances the reference-model velocity, the three
// leaky gain integrators and the clamped gains. All fourteen products of a
// sample go one after another through a single shared multiplier, so a new sample
// is accepted only once the previous one has finished all its products and its drive
// has been loaded into the output register.
// A sample can be accepted while the previous drive still waits at the output.
// Register writes are taken every cycle.
module mrac_drive_controller #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic     clk,
  input logic     rst_n,
  mrac_in_if.sink   in_ch,
  mrac_out_if.source out_ch,
  mrac_cfg_if.sink  cfg_ch
);
  import mrac_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int SW   = DATA_WIDTH + 2;
  localparam int OPW  = mag_width(DATA_WIDTH) + 1;
  localparam longint DMAX    = (longint'(1) <<< (W - 1)) - 1;
  localparam longint LIM_RAW = longint'(GAIN_LIMIT) <<< FRAC_BITS;
  localparam logic signed [W-1:0] GAIN_LIM = W'((LIM_RAW > DMAX) ? DMAX : LIM_RAW);
  localparam logic signed [SW-1:0] SUM_MAX = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {3'b111, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
    if (x > SUM_MAX) return SUM_MAX[W-1:0];
    if (x < SUM_MIN) return SUM_MIN[W-1:0];
    return x[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sign_times(input logic signed [W-1:0] v,
                                                     input logic signed [W-1:0] x);
    if (v[W-1]) return sat_w(-SW'(x));
    if (v != '0) return x;
    return '0;
  endfunction

  function automatic logic signed [W-1:0] clamp_gain(input logic signed [W-1:0] x);
    if (x > GAIN_LIM) return GAIN_LIM;
    if (x < -GAIN_LIM) return -GAIN_LIM;
    return x;
  endfunction

  // configuration
  logic [CFG_GAIN_W-1:0] adapt_r [3];
  logic [CFG_GAIN_W-1:0] leak_r  [3];
  logic [CFG_TS_W-1:0]   ts_r;

  // controller state
  state_t                state_r, state_nxt;
  step_t                 step_r, step_nxt, issue_step;
  logic signed [W-1:0]   integ_now_r  [3];
  logic signed [W-1:0]   integ_prev_r [3];
  logic signed [W-1:0]   gain_r       [3];
  logic signed [W-1:0]   rp_r;
  logic signed [W-1:0]   vm_r;

  // per-sample working values
  logic signed [W-1:0]   v_r, r_r, pa_r, u_r, e_r;
  logic signed [W-1:0]   k_r [3];
  logic signed [W-1:0]   q_r [3];

  logic                  out_valid_r, out_valid_nxt;
  logic signed [W-1:0]   out_drive_r;

  mul_ctl_t              mul_ctl;
  logic signed [OPW-1:0] op_a, op_b;
  logic                  mul_done;
  logic signed [W-1:0]   mul_result;

  logic accept, wb_en, last_wb, out_free, out_load, issue;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign wb_en    = (state_r == ST_RUN) && mul_done;
  assign last_wb  = wb_en && (step_r == STEP_L3);
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = out_free && (last_wb || state_r == ST_HOLD);
  assign issue    = (state_r == ST_ISSUE) || (wb_en && step_r != STEP_L3);
  assign issue_step = (state_r == ST_ISSUE) ? step_r : step_t'(step_r + 1'b1);

  // ---------------- register writes ----------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adapt_r[0] <= GAIN_VEL_RST;
      adapt_r[1] <= GAIN_ACC_RST;
      adapt_r[2] <= GAIN_FRIC_RST;
      leak_r[0]  <= LEAK_RST;
      leak_r[1]  <= LEAK_RST;
      leak_r[2]  <= LEAK_RST;
      ts_r       <= PERIOD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_GAIN_VEL:  adapt_r[0] <= cfg_ch.data[CFG_GAIN_W-1:0];
        CFG_GAIN_ACC:  adapt_r[1] <= cfg_ch.data[CFG_GAIN_W-1:0];
        CFG_GAIN_FRIC: adapt_r[2] <= cfg_ch.data[CFG_GAIN_W-1:0];
        CFG_LEAK_VEL:  leak_r[0]  <= cfg_ch.data[CFG_GAIN_W-1:0];
        CFG_LEAK_ACC:  leak_r[1]  <= cfg_ch.data[CFG_GAIN_W-1:0];
        CFG_LEAK_FRIC: leak_r[2]  <= cfg_ch.data[CFG_GAIN_W-1:0];
        CFG_PERIOD:    ts_r       <= cfg_ch.data[CFG_TS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- operand select ----------------
  always_comb begin
    op_a = '0;
    op_b = '0;
    mul_ctl.half = 1'b0;
    case (issue_step)
      STEP_PA: begin op_a = OPW'(gain_r[0]); op_b = OPW'(v_r); end
      STEP_PB: begin op_a = OPW'(gain_r[1]); op_b = OPW'(r_r); end
      STEP_PC: begin
        op_a = OPW'(ts_r);
        op_b = OPW'(SW'(r_r) + SW'(rp_r));
        mul_ctl.half = 1'b1;
      end
      STEP_K1: begin
        op_a = OPW'(SW'(integ_now_r[0]) + SW'(integ_prev_r[0]));
        op_b = OPW'(ts_r);
        mul_ctl.half = 1'b1;
      end
      STEP_K2: begin
        op_a = OPW'(SW'(integ_now_r[1]) + SW'(integ_prev_r[1]));
        op_b = OPW'(ts_r);
        mul_ctl.half = 1'b1;
      end
      STEP_K3: begin
        op_a = OPW'(SW'(integ_now_r[2]) + SW'(integ_prev_r[2]));
        op_b = OPW'(ts_r);
        mul_ctl.half = 1'b1;
      end
      STEP_Q1: begin op_a = OPW'(adapt_r[0]); op_b = OPW'(e_r); end
      STEP_Q2: begin op_a = OPW'(adapt_r[1]); op_b = OPW'(e_r); end
      STEP_Q3: begin op_a = OPW'(adapt_r[2]); op_b = OPW'(e_r); end
      STEP_T1: begin op_a = OPW'(q_r[0]); op_b = OPW'(v_r); end
      STEP_T2: begin op_a = OPW'(q_r[1]); op_b = OPW'(r_r); end
      STEP_L1: begin op_a = OPW'(leak_r[0]); op_b = OPW'(k_r[0]); end
      STEP_L2: begin op_a = OPW'(leak_r[1]); op_b = OPW'(k_r[1]); end
      STEP_L3: begin op_a = OPW'(leak_r[2]); op_b = OPW'(k_r[2]); end
      default: ;
    endcase
    mul_ctl.start = issue;
  end

  mrac_fxmul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_fxmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mul_ctl),
    .op_a   (op_a),
    .op_b   (op_b),
    .done   (mul_done),
    .result (mul_result)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_ISSUE;
          step_nxt  = STEP_PA;
        end
      end
      ST_ISSUE: state_nxt = ST_RUN;
      ST_RUN: begin
        if (last_wb) state_nxt = out_free ? ST_IDLE : ST_HOLD;
        else if (wb_en) step_nxt = step_t'(step_r + 1'b1);
      end
      ST_HOLD: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_PA;
      out_valid_r <= 1'b0;
      rp_r        <= '0;
      vm_r        <= '0;
      for (int i = 0; i < 3; i++) begin
        integ_now_r[i]  <= '0;
        integ_prev_r[i] <= '0;
        gain_r[i]       <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (wb_en) begin
        case (step_r)
          STEP_PC: begin
            vm_r <= sat_w(SW'(vm_r) + SW'(mul_result));
            rp_r <= r_r;
          end
          STEP_L1: begin
            integ_prev_r[0] <= integ_now_r[0];
            integ_now_r[0]  <= sat_w(SW'(integ_now_r[0]) + SW'(q_r[0]) - SW'(mul_result));
            gain_r[0]       <= clamp_gain(k_r[0]);
          end
          STEP_L2: begin
            integ_prev_r[1] <= integ_now_r[1];
            integ_now_r[1]  <= sat_w(SW'(integ_now_r[1]) + SW'(q_r[1]) - SW'(mul_result));
            gain_r[1]       <= clamp_gain(k_r[1]);
          end
          STEP_L3: begin
            integ_prev_r[2] <= integ_now_r[2];
            integ_now_r[2]  <= sat_w(SW'(integ_now_r[2]) + SW'(sign_times(v_r, q_r[2]))
                                     - SW'(mul_result));
            gain_r[2]       <= clamp_gain(k_r[2]);
          end
          default: ;
        endcase
      end
    end
  end

  // working values, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      v_r <= in_ch.velocity;
      r_r <= in_ch.desired_accel;
    end
    if (wb_en) begin
      case (step_r)
        STEP_PA: pa_r <= mul_result;
        STEP_PB: u_r  <= sat_w(SW'(pa_r) + SW'(mul_result) + SW'(sign_times(v_r, gain_r[2])));
        STEP_K1: begin
          k_r[0] <= mul_result;
          e_r    <= sat_w(SW'(v_r) - SW'(vm_r));   // model velocity already advanced
        end
        STEP_K2: k_r[1] <= mul_result;
        STEP_K3: k_r[2] <= mul_result;
        STEP_Q1: q_r[0] <= mul_result;
        STEP_Q2: q_r[1] <= mul_result;
        STEP_Q3: q_r[2] <= mul_result;
        STEP_T1: q_r[0] <= mul_result;
        STEP_T2: q_r[1] <= mul_result;
        default: ;
      endcase
    end
    if (out_load) out_drive_r <= u_r;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = out_drive_r;

endmodule

### src/mrac_fxmul.sv
// ----------------------------------------------------------------------------
// mrac_fxmul: shared fixed-point multiplier
// Sign-magnitude product built from two partial products in the M_HI and M_LO states,
// then shifted right by FRAC_BITS (or FRAC_BITS+1), truncated toward zero
// and saturated to the data range; the result is registered in M_FIN.
// ----------------------------------------------------------------------------
module mrac_fxmul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mrac_pkg::mul_ctl_t           ctl,
  input  logic signed [mrac_pkg::mag_width(DATA_WIDTH):0] op_a,
  input  logic signed [mrac_pkg::mag_width(DATA_WIDTH):0] op_b,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] result
);
  import mrac_pkg::*;

  localparam int MAGW = mag_width(DATA_WIDTH);
  localparam int OPW  = MAGW + 1;
  localparam int DIG  = (MAGW + 1) / 2;
  localparam int MBW  = 2 * DIG;
  localparam int PW   = MAGW + MBW;
  localparam logic [PW-1:0] QMAX = {{(PW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [PW-1:0] QMIN = QMAX + 1'b1;

  mul_state_t             state_r, state_nxt;
  logic [MAGW-1:0]        ma_r;
  logic [MBW-1:0]         mb_r;
  logic [PW-1:0]          acc_r;
  logic                   neg_r;
  logic                   half_r;
  logic                   done_r;
  logic [DATA_WIDTH-1:0]  result_r;

  logic [OPW-1:0]         abs_a, abs_b;
  logic [MAGW+DIG-1:0]    pp;
  logic [PW-1:0]          q;
  logic [DATA_WIDTH-1:0]  q_sat;

  assign abs_a = op_a[OPW-1] ? (~op_a + 1'b1) : op_a;
  assign abs_b = op_b[OPW-1] ? (~op_b + 1'b1) : op_b;
  assign pp    = ma_r * mb_r[MBW-1 -: DIG];

  always_comb begin
    q = half_r ? (acc_r >> (FRAC_BITS + 1)) : (acc_r >> FRAC_BITS);
    if (neg_r) begin
      q_sat = (q > QMIN) ? QMIN[DATA_WIDTH-1:0] : -q[DATA_WIDTH-1:0];
    end else begin
      q_sat = (q > QMAX) ? QMAX[DATA_WIDTH-1:0] : q[DATA_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      M_IDLE:  state_nxt = M_IDLE;
      M_HI:    state_nxt = M_LO;
      M_LO:    state_nxt = M_FIN;
      M_FIN:   state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
    if (ctl.start) state_nxt = M_HI;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == M_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      ma_r   <= abs_a[MAGW-1:0];
      mb_r   <= MBW'(abs_b[MAGW-1:0]);
      acc_r  <= '0;
      neg_r  <= op_a[OPW-1] ^ op_b[OPW-1];
      half_r <= ctl.half;
    end else if (state_r == M_HI || state_r == M_LO) begin
      acc_r <= {acc_r[PW-DIG-1:0], {DIG{1'b0}}} + PW'(pp);
      mb_r  <= {mb_r[MBW-DIG-1:0], {DIG{1'b0}}};
    end
    if (state_r == M_FIN) result_r <= q_sat;
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

### src/mrac_chk.sv
// ----------------------------------------------------------------------------
// mrac_chk: port-level checks of the adaptive drive controller
// Watches the handshakes of the top level over time.
// ----------------------------------------------------------------------------
module mrac_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);

  // a pending drive transaction is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("drive transaction dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("drive valid set after reset");

  // one sample at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while busy");

  // a drive does not appear straight after its sample is accepted
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("drive appeared right after sample");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> cfg_ready)
    else $error("register port not ready");

endmodule

bind mrac_drive_controller mrac_chk u_mrac_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_ready (cfg_ch.ready)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the adaptive drive controller
// Bursty samples and a stalling drive sink. Register settings change between
// phases while the block is idle. A cycle-free predictor of the control law,
// the reference-model velocity and the leaky gain integrators tracks every
// sample transaction. Each drive transaction is checked against it in order.
// ----------------------------------------------------------------------------
module tb;
  import mrac_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam longint DATA_MAX = 64'sd2147483647;
  localparam longint DATA_MIN = -64'sd2147483648;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 190;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 64;
  // index outside the register map; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef struct {
    logic signed [DW-1:0] vel;
    logic signed [DW-1:0] acc;
  } sample_t;

  logic clk;
  logic rst_n;

  mrac_in_if #(.DATA_WIDTH(DW)) in_ch ();
  mrac_out_if #(.DATA_WIDTH(DW)) out_ch ();
  mrac_cfg_if cfg_ch ();

  mrac_drive_controller #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sample_t pending_q[$];
  logic signed [DW-1:0] drive_q[$];
  int errors = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  int ready_left = 0;
  logic ready_on = 1'b0;
  longint traj_vel = 0;

  // controller model: registers and state
  longint adapt_v, adapt_a, adapt_f, leak_v, leak_a, leak_f, period;
  longint integ_v, integ_a, integ_f, integ_v_old, integ_a_old, integ_f_old;
  longint k_vel, k_acc, k_fric, accel_last, model_vel;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat_data(input longint x);
    if (x > DATA_MAX) return DATA_MAX;
    if (x < DATA_MIN) return DATA_MIN;
    return x;
  endfunction

  // exact product, shifted right, truncated toward zero, saturated
  function automatic longint fx_mul(input longint a, input longint b, input int sh);
    logic [127:0] mag_a, mag_b, prod;
    logic neg;
    neg = (a < 0) != (b < 0);
    mag_a = (a < 0) ? 128'(-a) : 128'(a);
    mag_b = (b < 0) ? 128'(-b) : 128'(b);
    prod = (mag_a * mag_b) >> sh;
    if (neg) begin
      if (prod > 128'(DATA_MAX) + 1) return DATA_MIN;
      return -longint'(prod);
    end
    if (prod > 128'(DATA_MAX)) return DATA_MAX;
    return longint'(prod);
  endfunction

  function automatic longint signed_by(input int sg, input longint x);
    if (sg > 0) return x;
    if (sg < 0) return sat_data(-x);
    return 0;
  endfunction

  function automatic longint clamp_gain(input longint x);
    longint lim;
    lim = longint'(GAIN_LIMIT) <<< FB;
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic logic signed [DW-1:0] predict_drive(input sample_t s);
    longint v, r, u, e, k1, k2, k3, n1, n2, n3;
    int sg;
    v = longint'(s.vel);
    r = longint'(s.acc);
    sg = int'(v > 0) - int'(v < 0);
    // drive uses the gains left by the previous sample
    u = sat_data(fx_mul(k_vel, v, FB) + fx_mul(k_acc, r, FB) + signed_by(sg, k_fric));
    model_vel = sat_data(model_vel + fx_mul(period, r + accel_last, FB + 1));
    accel_last = r;
    e = sat_data(v - model_vel);
    k1 = fx_mul(integ_v + integ_v_old, period, FB + 1);
    k2 = fx_mul(integ_a + integ_a_old, period, FB + 1);
    k3 = fx_mul(integ_f + integ_f_old, period, FB + 1);
    // integrators see the unclamped gains
    n1 = sat_data(integ_v + fx_mul(fx_mul(adapt_v, e, FB), v, FB) - fx_mul(leak_v, k1, FB));
    n2 = sat_data(integ_a + fx_mul(fx_mul(adapt_a, e, FB), r, FB) - fx_mul(leak_a, k2, FB));
    n3 = sat_data(integ_f + signed_by(sg, fx_mul(adapt_f, e, FB)) - fx_mul(leak_f, k3, FB));
    integ_v_old = integ_v;
    integ_a_old = integ_a;
    integ_f_old = integ_f;
    integ_v = n1;
    integ_a = n2;
    integ_f = n3;
    k_vel = clamp_gain(k1);
    k_acc = clamp_gain(k2);
    k_fric = clamp_gain(k3);
    return u[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return DATA_MAX[DW-1:0];
      1: return DATA_MIN[DW-1:0];
      2: return 0;
      3: return 1;
      4: return -1;
      default: return DATA_MIN[DW-1:0] + 1;
    endcase
  endfunction

  // mostly smooth trajectories that cross zero, then raw noise and extremes
  function automatic sample_t next_sample();
    sample_t s;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      traj_vel = traj_vel + longint'($urandom_range(0, 65536)) - 32768;
      if (traj_vel > (100 <<< FB)) traj_vel = 100 <<< FB;
      if (traj_vel < -(100 <<< FB)) traj_vel = -(100 <<< FB);
      s.vel = traj_vel[DW-1:0];
      s.acc = int'($urandom_range(0, 10 << FB)) - (5 << FB);
    end else if (kind < 85) begin
      s.vel = $urandom();
      s.acc = $urandom();
    end else begin
      s.vel = ($urandom_range(0, 2) == 0) ? $urandom() : pick_extreme();
      s.acc = ($urandom_range(0, 2) == 0) ? $urandom() : pick_extreme();
    end
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_gain_cfg();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'($urandom());
      default: return CFG_DATA_W'($urandom_range(0, 8 << FB));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_period_cfg();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DATA_W'(1 << FB);
      2: return CFG_DATA_W'($urandom());   // upper bits are dropped by the register
      3: return CFG_DATA_W'({CFG_TS_W{1'b1}});
      default: return CFG_DATA_W'($urandom_range(1, 6554));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] gv, ga, gf, lv, la, lf, ts);
    write_reg(CFG_GAIN_VEL, gv);
    write_reg(CFG_GAIN_ACC, ga);
    write_reg(CFG_GAIN_FRIC, gf);
    write_reg(CFG_LEAK_VEL, lv);
    write_reg(CFG_LEAK_ACC, la);
    write_reg(CFG_LEAK_FRIC, lf);
    write_reg(CFG_PERIOD, ts);
    cfg_ch.valid <= 1'b0;
  endtask

  // block is idle once every sample is out, every drive is back and it can take more;
  // checked mid-cycle so the edge's updates have settled, then back on the edge
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() != 0 || drive_q.size() != 0 || in_ch.valid || !in_ch.ready);
    @(posedge clk);
  endtask

  task automatic push_directed(input longint v, input longint r);
    sample_t s;
    s.vel = v[DW-1:0];
    s.acc = r[DW-1:0];
    pending_q.push_back(s);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    sample_t cur;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.velocity <= cur.vel;
        in_ch.desired_accel <= cur.acc;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: alternating ready runs and stalls, with an occasional long run
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
    end else begin
      ready_on = !ready_on;
      if (ready_on)
        ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 20);
      else
        ready_left = $urandom_range(1, 90);
    end
    out_ch.ready <= ready_on;
  end

  // monitor: register writes and samples feed the model, drives are checked
  always @(posedge clk) begin
    logic signed [DW-1:0] want;
    sample_t s;
    if (!rst_n) begin
      adapt_v = longint'(GAIN_VEL_RST);
      adapt_a = longint'(GAIN_ACC_RST);
      adapt_f = longint'(GAIN_FRIC_RST);
      leak_v = longint'(LEAK_RST);
      leak_a = longint'(LEAK_RST);
      leak_f = longint'(LEAK_RST);
      period = longint'(PERIOD_RST);
      integ_v = 0; integ_a = 0; integ_f = 0;
      integ_v_old = 0; integ_a_old = 0; integ_f_old = 0;
      k_vel = 0; k_acc = 0; k_fric = 0;
      accel_last = 0;
      model_vel = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_GAIN_VEL:  adapt_v = longint'(cfg_ch.data);
          CFG_GAIN_ACC:  adapt_a = longint'(cfg_ch.data);
          CFG_GAIN_FRIC: adapt_f = longint'(cfg_ch.data);
          CFG_LEAK_VEL:  leak_v = longint'(cfg_ch.data);
          CFG_LEAK_ACC:  leak_a = longint'(cfg_ch.data);
          CFG_LEAK_FRIC: leak_f = longint'(cfg_ch.data);
          CFG_PERIOD:    period = longint'(cfg_ch.data[CFG_TS_W-1:0]);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          $display("%0t: drive %0d with no result pending", $time, out_ch.drive);
          errors++;
        end else begin
          want = drive_q.pop_front();
          if (out_ch.drive !== want) begin
            $display("%0t: drive mismatch: expected %0d, actual %0d",
                     $time, want, out_ch.drive);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        s.vel = in_ch.velocity;
        s.acc = in_ch.desired_accel;
        drive_q.push_back(predict_drive(s));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.velocity = '0;
    in_ch.desired_accel = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_GAIN_VEL;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and sign cases under reset settings
    push_directed(0, 0);
    push_directed(1, -1);
    push_directed(-1, 1);
    push_directed(DATA_MAX, 0);
    push_directed(DATA_MIN, 0);
    push_directed(0, DATA_MAX);
    push_directed(0, DATA_MIN);
    push_directed(DATA_MAX, DATA_MAX);
    push_directed(DATA_MIN, DATA_MIN);
    push_directed(DATA_MAX, DATA_MIN);
    push_directed(DATA_MIN, DATA_MAX);
    push_directed(1 <<< FB, 1 <<< FB);
    push_directed(-(3 <<< FB), 2 <<< FB);
    push_directed(10 <<< FB, 0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_setting('1, '1, '1, '1, '1, '1, CFG_DATA_W'(1 << FB));
        1: apply_setting('0, '0, '0, '0, '0, '0, '0);
        2: apply_setting(GAIN_VEL_RST, GAIN_ACC_RST, GAIN_FRIC_RST,
                         LEAK_RST, LEAK_RST, LEAK_RST, CFG_DATA_W'(PERIOD_RST));
        default: begin
          write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom()));
          apply_setting(rand_gain_cfg(), rand_gain_cfg(), rand_gain_cfg(),
                        rand_gain_cfg(), rand_gain_cfg(), rand_gain_cfg(),
                        rand_period_cfg());
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) pending_q.push_back(next_sample());
      // wait here until every drive is back before the next setting
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
